/* hdl/length_prefixed_request_deframer_defines.svh */
// assertion macros used by the deframer decode module
`ifndef LENGTH_PREFIXED_REQUEST_DEFRAMER_DEFINES_SVH
`define LENGTH_PREFIXED_REQUEST_DEFRAMER_DEFINES_SVH

// same-cycle implication, checked at every rising edge outside reset
`define LPRD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("lprd check failed");

// next-cycle implication, checked at every rising edge outside reset
`define LPRD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("lprd check failed");

`endif

/* hdl/lprd_pkg.sv */
// shared types and constants of the request deframer
package lprd_pkg;

	localparam int unsigned HdrBytes   = 4;
	localparam int unsigned SizeBytes  = 2;
	localparam logic [15:0] MaxObjReset = 16'd128;

	// parsing phase, one-hot
	typedef enum logic [2:0] {
		PH_HEADER  = 3'b001,
		PH_SIZE    = 3'b010,
		PH_PAYLOAD = 3'b100
	} phase_t;

	// byte role codes
	localparam logic [1:0] ROLE_HEADER  = 2'd0;
	localparam logic [1:0] ROLE_SIZE    = 2'd1;
	localparam logic [1:0] ROLE_PAYLOAD = 2'd2;

	// error codes
	localparam logic [1:0] ERR_NONE    = 2'd0;
	localparam logic [1:0] ERR_OVER    = 2'd1;
	localparam logic [1:0] ERR_OVERSIZE = 2'd2;

	// header field byte positions
	localparam logic [1:0] HDR_SIZE_LO = 2'd0;
	localparam logic [1:0] HDR_SIZE_HI = 2'd1;
	localparam logic [1:0] HDR_ID_LO   = 2'd2;
	localparam logic [1:0] HDR_ID_HI   = 2'd3;

	// one result item
	typedef struct packed {
		logic [7:0]  byte_out;
		logic [1:0]  byte_role;
		logic [15:0] request_tag;
		logic [15:0] object_number;
		logic        request_start;
		logic        object_start;
		logic        object_end;
		logic        request_end;
		logic [1:0]  error_code;
	} result_t;

endpackage

/* hdl/lprd_in_reg.sv */
// input register stage for the byte stream
module lprd_in_reg
	import lprd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	output logic       valid_s1,
	output logic [7:0] data_s1,
	input  logic       take_s1
);

	logic       vld_s1;
	logic [7:0] byte_s1;

	// accept when empty or when the held byte moves on this cycle
	assign in_ready = !vld_s1 || take_s1;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	// byte holding register
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= data_byte;
		end
	end

	assign valid_s1 = vld_s1;
	assign data_s1  = byte_s1;

endmodule

/* hdl/lprd_deframe.sv */
// parsing state, per-byte decode and result register
`include "length_prefixed_request_deframer_defines.svh"

module lprd_deframe
	import lprd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic [15:0] max_object_size,
	input  logic        valid_s1,
	input  logic [7:0]  data_s1,
	output logic        take_s1,
	output logic        out_valid,
	input  logic        out_ready,
	output result_t     result
);

	phase_t      phase_q, phase_d;
	logic [1:0]  fbc_q, fbc_d;
	logic [7:0]  hold_q, hold_d;
	logic [15:0] body_size_q, body_size_d;
	logic [15:0] req_id_q, req_id_d;
	logic [16:0] consumed_q, consumed_d;
	logic [15:0] obj_size_q, obj_size_d;
	logic [15:0] remaining_q, remaining_d;
	logic [15:0] obj_count_q, obj_count_d;

	logic        valid_s2;
	result_t     result_s2;
	result_t     res_d;
	logic        advance;
	logic        finish;
	logic [15:0] size_word;

	// the result register frees up when empty or when taken
	assign advance = !valid_s2 || out_ready;
	assign take_s1 = advance;
	assign size_word = {data_s1, hold_q};

	// per-byte decode
	always_comb begin
		phase_d     = phase_q;
		fbc_d       = fbc_q;
		hold_d      = hold_q;
		body_size_d = body_size_q;
		req_id_d    = req_id_q;
		consumed_d  = consumed_q;
		obj_size_d  = obj_size_q;
		remaining_d = remaining_q;
		obj_count_d = obj_count_q;
		finish      = 1'b0;
		res_d       = '0;
		res_d.byte_out = data_s1;

		unique case (phase_q)
			PH_SIZE: begin
				res_d.byte_role     = ROLE_SIZE;
				res_d.object_number = obj_count_q;
				consumed_d = consumed_q + 17'd1;
				if (fbc_q == 2'd0) begin
					hold_d = data_s1;
					fbc_d  = 2'd1;
				end else begin
					obj_size_d  = size_word;
					remaining_d = size_word;
					res_d.object_start = 1'b1;
					if (size_word > max_object_size) begin
						res_d.error_code = ERR_OVERSIZE;
					end
					if (size_word == 16'd0) begin
						finish = 1'b1;
					end else begin
						phase_d = PH_PAYLOAD;
						fbc_d   = 2'd0;
					end
				end
			end
			PH_PAYLOAD: begin
				res_d.byte_role     = ROLE_PAYLOAD;
				res_d.object_number = obj_count_q;
				consumed_d  = consumed_q + 17'd1;
				remaining_d = remaining_q - 16'd1;
				if (remaining_d == 16'd0) begin
					finish = 1'b1;
				end
			end
			default: begin
				// header phase
				res_d.byte_role = ROLE_HEADER;
				unique case (fbc_q)
					HDR_SIZE_LO: hold_d = data_s1;
					HDR_SIZE_HI: body_size_d = size_word;
					HDR_ID_LO:   hold_d = data_s1;
					HDR_ID_HI: begin
						req_id_d    = size_word;
						consumed_d  = 17'd0;
						obj_count_d = 16'd0;
						res_d.request_start = 1'b1;
					end
					default: hold_d = hold_q;
				endcase
				if (fbc_q == HDR_ID_HI) begin
					phase_d = PH_SIZE;
					fbc_d   = 2'd0;
				end else begin
					phase_d = PH_HEADER;
					fbc_d   = fbc_q + 2'd1;
				end
			end
		endcase

		// object completion and request end check
		if (finish) begin
			res_d.object_end = 1'b1;
			obj_count_d = obj_count_q + 16'd1;
			if (consumed_d >= {1'b0, body_size_q}) begin
				res_d.request_end = 1'b1;
				if (consumed_d > {1'b0, body_size_q}) begin
					res_d.error_code = ERR_OVER;
				end
				phase_d = PH_HEADER;
			end else begin
				phase_d = PH_SIZE;
			end
			fbc_d = 2'd0;
		end

		res_d.request_tag = req_id_d;
	end

	// parsing state, updated when a byte moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HEADER;
			fbc_q       <= 2'd0;
			hold_q      <= 8'd0;
			body_size_q <= 16'd0;
			req_id_q    <= 16'd0;
			consumed_q  <= 17'd0;
			obj_size_q  <= 16'd0;
			remaining_q <= 16'd0;
			obj_count_q <= 16'd0;
		end else if (valid_s1 && advance) begin
			phase_q     <= phase_d;
			fbc_q       <= fbc_d;
			hold_q      <= hold_d;
			body_size_q <= body_size_d;
			req_id_q    <= req_id_d;
			consumed_q  <= consumed_d;
			obj_size_q  <= obj_size_d;
			remaining_q <= remaining_d;
			obj_count_q <= obj_count_d;
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			result_s2 <= res_d;
		end
	end

	assign out_valid = valid_s2;
	assign result    = result_s2;

	// a request only ends where an object ends
	`LPRD_ASSERT_NOW(a_req_end_on_obj_end, clk, arst_n,
		valid_s2 && result_s2.request_end, result_s2.object_end)
	// overconsumption is only reported at the end of a request
	`LPRD_ASSERT_NOW(a_over_at_req_end, clk, arst_n,
		valid_s2 && (result_s2.error_code == ERR_OVER), result_s2.request_end)
	// a request end sends the parser back to the header
	`LPRD_ASSERT_NEXT(a_end_to_header, clk, arst_n,
		valid_s1 && advance && res_d.request_end, phase_q == PH_HEADER && fbc_q == 2'd0)
	// header bytes carry no object markers
	`LPRD_ASSERT_NOW(a_header_clean, clk, arst_n,
		valid_s2 && (result_s2.byte_role == ROLE_HEADER),
		!result_s2.object_start && !result_s2.object_end && result_s2.object_number == 16'd0)

endmodule

/* hdl/length_prefixed_request_deframer.sv */
// Length-prefixed request deframer: one byte in, one tagged result out per transfer.
// Each byte passes through an input register, combinational decode logic and a
// result register, so the block sustains one byte per clock while out_ready stays
// high. The result register holds each decoded result until out_ready takes it;
// the counter updates of the decode step set the clock limit. A request is a 4-byte
// header (little-endian body size, then request id) followed by objects, each a
// little-endian 16-bit size and its payload. max_object_size resets to 128.
// Write it through the cfg channel only while idle; the block does not enforce this.
module length_prefixed_request_deframer
	import lprd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  byte_out,
	output logic [1:0]  byte_role,
	output logic [15:0] request_tag,
	output logic [15:0] object_number,
	output logic        request_start,
	output logic        object_start,
	output logic        object_end,
	output logic        request_end,
	output logic [1:0]  error_code
);

	logic [15:0] max_obj_q;
	logic        valid_s1;
	logic [7:0]  data_s1;
	logic        take_s1;
	result_t     result;

	// configuration register, always ready for a transfer
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_obj_q <= MaxObjReset;
		end else if (cfg_valid && cfg_ready) begin
			max_obj_q <= cfg_data;
		end
	end

	// input register stage
	lprd_in_reg u_in_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.valid_s1  (valid_s1),
		.data_s1   (data_s1),
		.take_s1   (take_s1)
	);

	// decode and result stage
	lprd_deframe u_deframe (
		.clk             (clk),
		.arst_n          (arst_n),
		.max_object_size (max_obj_q),
		.valid_s1        (valid_s1),
		.data_s1         (data_s1),
		.take_s1         (take_s1),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.result          (result)
	);

	// result fields
	assign byte_out      = result.byte_out;
	assign byte_role     = result.byte_role;
	assign request_tag   = result.request_tag;
	assign object_number = result.object_number;
	assign request_start = result.request_start;
	assign object_start  = result.object_start;
	assign object_end    = result.object_end;
	assign request_end   = result.request_end;
	assign error_code    = result.error_code;

endmodule

/* tb/tb.sv */
// self-checking testbench for the length-prefixed request deframer
`timescale 1ns / 1ps

module tb;
	import lprd_pkg::*;

	// kinds of rows in the directed stimulus table
	typedef enum logic {
		ROW_BYTE,
		ROW_CFG
	} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		logic [15:0] value;
		bit          typed;
		result_t     want;
	} stim_row_t;

	localparam int unsigned IdlePercent  = 17;
	localparam int unsigned HoldCycles   = 80;
	localparam int unsigned PhaseBytes   = 70;
	localparam int unsigned MaxPrinted   = 40;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [15:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  data_byte;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  byte_out;
	logic [1:0]  byte_role;
	logic [15:0] request_tag;
	logic [15:0] object_number;
	logic        request_start;
	logic        object_start;
	logic        object_end;
	logic        request_end;
	logic [1:0]  error_code;

	length_prefixed_request_deframer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.data_byte     (data_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.byte_out      (byte_out),
		.byte_role     (byte_role),
		.request_tag   (request_tag),
		.object_number (object_number),
		.request_start (request_start),
		.object_start  (object_start),
		.object_end    (object_end),
		.request_end   (request_end),
		.error_code    (error_code)
	);

	// deframer state mirror
	phase_t      parse_phase;
	logic [1:0]  field_idx;
	logic [7:0]  low_hold;
	logic [15:0] body_len;
	logic [15:0] req_id;
	logic [16:0] consumed;
	logic [15:0] obj_size;
	logic [15:0] remaining;
	logic [15:0] obj_count;
	logic [15:0] max_obj;

	result_t     pending_results[$];
	stim_row_t   directed_rows[$];

	int unsigned mismatch_count = 0;
	int unsigned results_checked = 0;
	int unsigned bytes_sent = 0;
	int unsigned requests_seen = 0;
	int unsigned overrun_flags = 0;
	int unsigned oversize_flags = 0;
	int unsigned settings_used = 0;
	int unsigned hold_requests = 0;
	bit          calm = 1'b0;

	// clock
	initial clk = 1'b0;
	always #6 clk = ~clk;

	// run limit
	initial begin
		#3_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	// mismatch reporting
	task automatic report_mismatch(input string field, input int unsigned got,
			input int unsigned want);
		if (mismatch_count < MaxPrinted)
			$display("[%0t] result %0d: %s is %0h, predicted %0h", $realtime,
				results_checked, field, got, want);
		mismatch_count++;
	endtask

	function automatic result_t result_of(logic [7:0] b, logic [1:0] role,
			logic [15:0] tag, logic [15:0] num, logic rs, logic os, logic oe,
			logic re, logic [1:0] err);
		result_t r;
		r = '{b, role, tag, num, rs, os, oe, re, err};
		return r;
	endfunction

	task automatic reset_mirror();
		max_obj     = MaxObjReset;
		parse_phase = PH_HEADER;
		field_idx   = '0;
		low_hold    = '0;
		body_len    = '0;
		req_id      = '0;
		consumed    = '0;
		obj_size    = '0;
		remaining   = '0;
		obj_count   = '0;
	endtask

	// object completion: request end check against declared body size
	task automatic close_object(inout result_t r);
		r.object_end = 1'b1;
		obj_count    = obj_count + 16'd1;
		if (consumed >= {1'b0, body_len}) begin
			r.request_end = 1'b1;
			if (consumed > {1'b0, body_len})
				r.error_code = ERR_OVER;
			parse_phase = PH_HEADER;
		end else begin
			parse_phase = PH_SIZE;
		end
		field_idx = '0;
	endtask

	// predicted result of one byte, advancing the mirror
	task automatic decode_byte(input logic [7:0] b, output result_t r);
		r          = '0;
		r.byte_out = b;
		case (parse_phase)
			PH_SIZE: begin
				r.byte_role     = ROLE_SIZE;
				r.object_number = obj_count;
				consumed        = consumed + 17'd1;
				if (field_idx == 2'd0) begin
					low_hold  = b;
					field_idx = 2'd1;
				end else begin
					obj_size       = {b, low_hold};
					remaining      = obj_size;
					r.object_start = 1'b1;
					if (obj_size > max_obj)
						r.error_code = ERR_OVERSIZE;
					if (obj_size == 16'd0) begin
						close_object(r);
					end else begin
						parse_phase = PH_PAYLOAD;
						field_idx   = '0;
					end
				end
			end
			PH_PAYLOAD: begin
				r.byte_role     = ROLE_PAYLOAD;
				r.object_number = obj_count;
				consumed        = consumed + 17'd1;
				remaining       = remaining - 16'd1;
				if (remaining == 16'd0)
					close_object(r);
			end
			default: begin
				r.byte_role = ROLE_HEADER;
				case (field_idx)
					HDR_SIZE_LO: low_hold = b;
					HDR_SIZE_HI: body_len = {b, low_hold};
					HDR_ID_LO:   low_hold = b;
					default: begin
						req_id          = {b, low_hold};
						consumed        = '0;
						obj_count       = '0;
						r.request_start = 1'b1;
					end
				endcase
				if (field_idx == HDR_ID_HI) begin
					parse_phase = PH_SIZE;
					field_idx   = '0;
				end else begin
					field_idx = field_idx + 2'd1;
				end
			end
		endcase
		r.request_tag = req_id;
	endtask

	// one byte transfer, sometimes with valid dropped in front; valid stays up afterwards
	task automatic push_byte(input logic [7:0] b, input bit typed = 1'b0,
			input result_t want = '0);
		int unsigned gap;
		result_t     r;
		gap = 0;
		if (!calm && $urandom_range(99) < IdlePercent)
			gap = 1;
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid  <= 1'b1;
		data_byte <= b;
		do @(posedge clk); while (!in_ready);
		decode_byte(b, r);
		pending_results.push_back(typed ? want : r);
		bytes_sent++;
	endtask

	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// register write once every result has come back
	task automatic write_max(input logic [15:0] v);
		wait_idle();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		max_obj = v;
		settings_used++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// random byte that keeps any size field it lands on below 512
	function automatic logic [7:0] noise_byte();
		if ((parse_phase == PH_HEADER && field_idx == HDR_SIZE_HI) ||
				(parse_phase == PH_SIZE && field_idx == 2'd1))
			return 8'($urandom_range(1, 0));
		return 8'($urandom_range(255, 0));
	endfunction

	// feed bytes until the deframer expects a fresh header
	task automatic resync();
		int left;
		while (!(parse_phase == PH_HEADER && field_idx == HDR_SIZE_LO)) begin
			if (parse_phase == PH_SIZE && field_idx == 2'd0) begin
				left = int'(body_len) - int'(consumed);
				push_byte((left > 2) ? 8'((left - 2 > 255) ? 255 : left - 2) : 8'h00);
			end else if (parse_phase == PH_SIZE) begin
				push_byte(8'h00);
			end else begin
				push_byte(noise_byte());
			end
		end
	endtask

	// one request: mostly well formed, some with a wrong body size, some noise
	task automatic send_request();
		int          sizes[$];
		int          n_obj;
		int          total;
		int          body;
		int          pick;
		int          kind;
		int          sz;
		logic [15:0] id;
		kind  = $urandom_range(99);
		n_obj = $urandom_range(4, 1);
		total = 0;
		for (int i = 0; i < n_obj; i++) begin
			pick = $urandom_range(99);
			if (pick < 50)
				sz = $urandom_range(6, 0);
			else if (pick < 75)
				sz = $urandom_range(40, 7);
			else if (pick < 85)
				sz = (max_obj <= 300) ? int'(max_obj) : $urandom_range(40, 0);
			else if (pick < 95)
				sz = (max_obj < 300) ? int'(max_obj) + 1 : $urandom_range(40, 0);
			else
				sz = $urandom_range(200, 41);
			sizes.push_back(sz);
			total += 2 + sz;
		end
		body = total;
		if (kind < 8)
			body = total - $urandom_range((sizes[n_obj-1] < 2) ? 1 + sizes[n_obj-1] : 3, 1);
		else if (kind < 16)
			body = total + $urandom_range(4, 1);
		if (kind >= 16 && kind < 22) begin
			repeat ($urandom_range(10, 3))
				push_byte(noise_byte());
		end else begin
			id = 16'($urandom);
			push_byte(body[7:0]);
			push_byte(body[15:8]);
			push_byte(id[7:0]);
			push_byte(id[15:8]);
			foreach (sizes[i]) begin
				push_byte(8'(sizes[i]));
				push_byte(8'(sizes[i] >> 8));
				repeat (sizes[i])
					push_byte(8'($urandom_range(255, 0)));
			end
		end
		resync();
	endtask

	// receiver: random stalls, and a long hold-off when asked for
	initial begin
		int unsigned hold_served;
		int unsigned hold_left;
		hold_served = 0;
		hold_left   = 0;
		out_ready   = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_served != hold_requests) begin
				hold_served = hold_requests;
				hold_left   = HoldCycles;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= calm || ($urandom_range(99) >= IdlePercent);
			end
		end
	end

	// result checking against the oldest prediction
	always @(posedge clk) begin
		result_t seen;
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			seen = '{byte_out, byte_role, request_tag, object_number, request_start,
				object_start, object_end, request_end, error_code};
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result, byte", seen.byte_out, 0);
			end else begin
				want = pending_results.pop_front();
				if (seen.byte_out !== want.byte_out)
					report_mismatch("byte_out", seen.byte_out, want.byte_out);
				if (seen.byte_role !== want.byte_role)
					report_mismatch("byte_role", seen.byte_role, want.byte_role);
				if (seen.request_tag !== want.request_tag)
					report_mismatch("request_tag", seen.request_tag, want.request_tag);
				if (seen.object_number !== want.object_number)
					report_mismatch("object_number", seen.object_number,
						want.object_number);
				if (seen.request_start !== want.request_start)
					report_mismatch("request_start", seen.request_start,
						want.request_start);
				if (seen.object_start !== want.object_start)
					report_mismatch("object_start", seen.object_start, want.object_start);
				if (seen.object_end !== want.object_end)
					report_mismatch("object_end", seen.object_end, want.object_end);
				if (seen.request_end !== want.request_end)
					report_mismatch("request_end", seen.request_end, want.request_end);
				if (seen.error_code !== want.error_code)
					report_mismatch("error_code", seen.error_code, want.error_code);
				if (want.request_start)
					requests_seen++;
				if (want.error_code == ERR_OVER)
					overrun_flags++;
				if (want.error_code == ERR_OVERSIZE)
					oversize_flags++;
			end
			results_checked++;
		end
	end

	// stimulus
	initial begin
		logic [15:0] settings[7];
		int unsigned phase_start;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		data_byte = '0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		reset_mirror();

		// directed rows: header, zero-size object, overconsumption on payload and
		// on a size byte, empty body, oversize with a zero maximum, exact end
		directed_rows = '{
			'{ROW_BYTE, 16'h04, 1'b1, result_of(8'h04, ROLE_HEADER, 16'h0, 16'd0,
				0, 0, 0, 0, ERR_NONE)},
			'{ROW_BYTE, 16'h00, 1'b1, result_of(8'h00, ROLE_HEADER, 16'h0, 16'd0,
				0, 0, 0, 0, ERR_NONE)},
			'{ROW_BYTE, 16'h34, 1'b1, result_of(8'h34, ROLE_HEADER, 16'h0, 16'd0,
				0, 0, 0, 0, ERR_NONE)},
			'{ROW_BYTE, 16'h12, 1'b1, result_of(8'h12, ROLE_HEADER, 16'h1234, 16'd0,
				1, 0, 0, 0, ERR_NONE)},
			'{ROW_BYTE, 16'h00, 1'b1, result_of(8'h00, ROLE_SIZE, 16'h1234, 16'd0,
				0, 0, 0, 0, ERR_NONE)},
			'{ROW_BYTE, 16'h00, 1'b1, result_of(8'h00, ROLE_SIZE, 16'h1234, 16'd0,
				0, 1, 1, 0, ERR_NONE)},
			'{ROW_BYTE, 16'h01, 1'b0, '0},
			'{ROW_BYTE, 16'h00, 1'b0, '0},
			'{ROW_BYTE, 16'hFF, 1'b1, result_of(8'hFF, ROLE_PAYLOAD, 16'h1234, 16'd1,
				0, 0, 1, 1, ERR_OVER)},
			'{ROW_BYTE, 16'h00, 1'b0, '0},
			'{ROW_BYTE, 16'h00, 1'b0, '0},
			'{ROW_BYTE, 16'hFF, 1'b0, '0},
			'{ROW_BYTE, 16'hFF, 1'b1, result_of(8'hFF, ROLE_HEADER, 16'hFFFF, 16'd0,
				1, 0, 0, 0, ERR_NONE)},
			'{ROW_BYTE, 16'h00, 1'b0, '0},
			'{ROW_BYTE, 16'h00, 1'b1, result_of(8'h00, ROLE_SIZE, 16'hFFFF, 16'd0,
				0, 1, 1, 1, ERR_OVER)},
			'{ROW_CFG, 16'h0000, 1'b0, '0},
			'{ROW_BYTE, 16'h03, 1'b0, '0},
			'{ROW_BYTE, 16'h00, 1'b0, '0},
			'{ROW_BYTE, 16'h00, 1'b0, '0},
			'{ROW_BYTE, 16'h00, 1'b1, result_of(8'h00, ROLE_HEADER, 16'h0000, 16'd0,
				1, 0, 0, 0, ERR_NONE)},
			'{ROW_BYTE, 16'h01, 1'b0, '0},
			'{ROW_BYTE, 16'h00, 1'b1, result_of(8'h00, ROLE_SIZE, 16'h0000, 16'd0,
				0, 1, 0, 0, ERR_OVERSIZE)},
			'{ROW_BYTE, 16'hAA, 1'b1, result_of(8'hAA, ROLE_PAYLOAD, 16'h0000, 16'd0,
				0, 0, 1, 1, ERR_NONE)}
		};

		// reset
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_CFG)
				write_max(directed_rows[i].value);
			else
				push_byte(directed_rows[i].value[7:0], directed_rows[i].typed,
					directed_rows[i].want);
		end

		// random requests under several maximum object sizes
		settings = '{MaxObjReset, 16'h0000, 16'hFFFF, 16'h0001,
			16'($urandom_range(60, 2)), 16'($urandom), MaxObjReset};
		for (int s = 0; s < 7; s++) begin
			write_max(settings[s]);
			calm = (s == 4);
			if (s == 2)
				hold_requests++;
			phase_start = bytes_sent;
			while (bytes_sent - phase_start < PhaseBytes)
				send_request();
		end
		calm = 1'b0;

		// drain and let any stray result show up
		wait_idle();
		repeat (8) @(posedge clk);

		$display("run covered %0d bytes, %0d results, %0d request starts", bytes_sent,
			results_checked, requests_seen);
		$display("%0d overconsumption and %0d oversize flags over %0d register writes",
			overrun_flags, oversize_flags, settings_used);
		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
